@@ rtl/core/refpack_stream_profiler_macros.svh @@
// assertion macros for the stream profiler
`ifndef REFPACK_STREAM_PROFILER_MACROS_SVH
`define REFPACK_STREAM_PROFILER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSP_ASSERT(lbl, prop, msg)
`define RSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/rsp_pkg.sv @@
// shared types, codes and bucket functions of the stream profiler
package rsp_pkg;

  localparam int COUNTER_BITS = 32;
  localparam int NUM_CNT = 32;
  localparam int EVQ_DEPTH = 4;

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_CONTROL = 4'd1;
  localparam logic [3:0] PH_SHORT1  = 4'd2;
  localparam logic [3:0] PH_MED1    = 4'd3;
  localparam logic [3:0] PH_MED2    = 4'd4;
  localparam logic [3:0] PH_LONG1   = 4'd5;
  localparam logic [3:0] PH_LONG2   = 4'd6;
  localparam logic [3:0] PH_LONG3   = 4'd7;
  localparam logic [3:0] PH_CMDLIT  = 4'd8;
  localparam logic [3:0] PH_TERMLIT = 4'd9;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_HEADER   = 4'd1;
  localparam logic [3:0] ST_SIZE     = 4'd2;
  localparam logic [3:0] ST_NOCTRL   = 4'd3;
  localparam logic [3:0] ST_SHORT    = 4'd4;
  localparam logic [3:0] ST_MEDIUM   = 4'd5;
  localparam logic [3:0] ST_LONG     = 4'd6;
  localparam logic [3:0] ST_TERMLIT  = 4'd7;
  localparam logic [3:0] ST_CMDLIT   = 4'd8;
  localparam logic [3:0] ST_DISTANCE = 4'd9;
  localparam logic [3:0] ST_MISMATCH = 4'd10;

  localparam logic [4:0] IDX_CMD     = 5'd0;
  localparam logic [4:0] IDX_LITB    = 5'd1;
  localparam logic [4:0] IDX_MATCHB  = 5'd2;
  localparam logic [4:0] IDX_OVLB    = 5'd3;
  localparam logic [4:0] IDX_CLASS   = 5'd4;
  localparam logic [4:0] IDX_LITBKT  = 5'd8;
  localparam logic [4:0] IDX_LENBKT  = 5'd16;
  localparam logic [4:0] IDX_DISTBKT = 5'd23;
  localparam logic [4:0] IDX_LAST    = 5'd31;

  localparam logic [1:0] CLS_SHORT  = 2'd0;
  localparam logic [1:0] CLS_MEDIUM = 2'd1;
  localparam logic [1:0] CLS_LONG   = 2'd2;
  localparam logic [1:0] CLS_LITRL  = 2'd3;

  typedef struct packed {
    logic        do_cmd;
    logic        do_term;
    logic [1:0]  cls;
    logic [6:0]  lits;
    logic [2:0]  lit_bkt;
    logic [10:0] len;
    logic [2:0]  len_bkt;
    logic [3:0]  dist_bkt;
    logic        ovl;
    logic        do_run;
    logic [3:0]  status;
    logic [31:0] offset;
    logic [31:0] produced;
    logic        do_clear;
  } rsp_event_t;

  function automatic logic [2:0] lit_bucket(input logic [6:0] n);
    if (n <= 7'd3) return n[2:0];
    else if (n <= 7'd15) return 3'd4;
    else if (n <= 7'd31) return 3'd5;
    else if (n <= 7'd63) return 3'd6;
    else return 3'd7;
  endfunction

  function automatic logic [2:0] len_bucket(input logic [10:0] n);
    if (n <= 11'd7) return 3'd0;
    else if (n <= 11'd15) return 3'd1;
    else if (n <= 11'd31) return 3'd2;
    else if (n <= 11'd63) return 3'd3;
    else if (n <= 11'd127) return 3'd4;
    else if (n <= 11'd255) return 3'd5;
    else return 3'd6;
  endfunction

  function automatic logic [3:0] dist_bucket(input logic [17:0] n);
    if (n <= 18'd1) return 4'd0;
    else if (n == 18'd2) return 4'd1;
    else if (n <= 18'd4) return 4'd2;
    else if (n <= 18'd8) return 4'd3;
    else if (n <= 18'd15) return 4'd4;
    else if (n <= 18'd31) return 4'd5;
    else if (n <= 18'd63) return 4'd6;
    else if (n <= 18'd255) return 4'd7;
    else return 4'd8;
  endfunction

  function automatic logic [31:0] back_off(input logic [31:0] pos, input logic [7:0] d);
    if ({24'd0, d} > pos) return 32'd0;
    else return pos - {24'd0, d};
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [10:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {22'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ rtl/core/rsp_front.sv @@
// front end: header and control code parser, emits counter and run events
module rsp_front
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] stream_byte,
  input  logic       last_byte,
  output logic       ev_valid,
  output rsp_event_t ev
);

  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        lhf_r, lhf_nxt;
  logic [7:0]  cb0_r, cb0_nxt, cb1_r, cb1_nxt, cb2_r, cb2_nxt;
  logic [23:0] exp_r, exp_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [6:0]  litleft_r, litleft_nxt;
  logic [6:0]  plits_r, plits_nxt;
  logic [10:0] plen_r, plen_nxt;
  logic [17:0] pdist_r, pdist_nxt;
  logic [1:0]  pcls_r, pcls_nxt;
  logic        absorb_r, absorb_nxt;

  logic [31:0] posn, skip;
  logic        lhf_v;
  logic        sc_go;
  logic [1:0]  sc_cls;
  logic [6:0]  sc_lits;
  logic [10:0] sc_len;
  logic [17:0] sc_dist;
  logic        do_res;
  logic [1:0]  r_cls;
  logic [6:0]  r_lits;
  logic [10:0] r_len;
  logic [17:0] r_dist;
  logic        do_term;
  logic [6:0]  t_lits;
  logic        have_st;
  logic [3:0]  st;
  logic [31:0] off;
  logic [7:0]  b;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt = pos_r;
    lhf_nxt = lhf_r;
    cb0_nxt = cb0_r;
    cb1_nxt = cb1_r;
    cb2_nxt = cb2_r;
    exp_nxt = exp_r;
    prod_nxt = prod_r;
    litleft_nxt = litleft_r;
    plits_nxt = plits_r;
    plen_nxt = plen_r;
    pdist_nxt = pdist_r;
    pcls_nxt = pcls_r;
    absorb_nxt = absorb_r;
    ev = '0;
    b = stream_byte;
    posn = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;
    lhf_v = lhf_r;
    skip = 32'd2;
    sc_go = 1'b0;
    sc_cls = CLS_SHORT;
    sc_lits = '0;
    sc_len = '0;
    sc_dist = '0;
    do_res = 1'b0;
    r_cls = pcls_r;
    r_lits = plits_r;
    r_len = plen_r;
    r_dist = pdist_r;
    do_term = 1'b0;
    t_lits = {5'd0, cb0_r[1:0]};
    have_st = 1'b0;
    st = ST_OK;
    off = 32'd0;

    if (absorb_r) begin
      if (last_byte) begin
        ev.do_clear = 1'b1;
      end
    end else begin
      pos_nxt = posn;
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == 32'd0) lhf_v = b[0];
          lhf_nxt = lhf_v;
          skip = lhf_v ? 32'd5 : 32'd2;
          if (pos_r >= skip) exp_nxt = {exp_r[15:0], b};
          if (pos_r == skip + 32'd2) phase_nxt = PH_CONTROL;
        end
        PH_CONTROL: begin
          cb0_nxt = b;
          priority if (!b[7]) begin
            phase_nxt = PH_SHORT1;
          end else if (!b[6]) begin
            phase_nxt = PH_MED1;
          end else if (!b[5]) begin
            phase_nxt = PH_LONG1;
          end else if (b[4:0] > 5'd27) begin
            litleft_nxt = {5'd0, b[1:0]};
            t_lits = {5'd0, b[1:0]};
            if (b[1:0] == 2'd0) do_term = 1'b1;
            else phase_nxt = PH_TERMLIT;
          end else begin
            sc_go = 1'b1;
            sc_cls = CLS_LITRL;
            sc_lits = {b[4:0], 2'b00} + 7'd4;
          end
        end
        PH_SHORT1: begin
          cb1_nxt = b;
          sc_go = 1'b1;
          sc_cls = CLS_SHORT;
          sc_lits = {5'd0, cb0_r[1:0]};
          sc_len = {8'd0, cb0_r[4:2]} + 11'd3;
          sc_dist = {10'd0, b} + {8'd0, cb0_r[6:5], 8'd0} + 18'd1;
        end
        PH_MED1: begin
          cb1_nxt = b;
          phase_nxt = PH_MED2;
        end
        PH_MED2: begin
          cb2_nxt = b;
          sc_go = 1'b1;
          sc_cls = CLS_MEDIUM;
          sc_lits = {5'd0, cb1_r[7:6]};
          sc_len = {5'd0, cb0_r[5:0]} + 11'd4;
          sc_dist = {4'd0, cb1_r[5:0], b} + 18'd1;
        end
        PH_LONG1: begin
          cb1_nxt = b;
          phase_nxt = PH_LONG2;
        end
        PH_LONG2: begin
          cb2_nxt = b;
          phase_nxt = PH_LONG3;
        end
        PH_LONG3: begin
          sc_go = 1'b1;
          sc_cls = CLS_LONG;
          sc_lits = {5'd0, cb0_r[1:0]};
          sc_len = {1'b0, cb0_r[3:2], b} + 11'd5;
          sc_dist = {1'b0, cb0_r[4], cb1_r, cb2_r} + 18'd1;
        end
        PH_CMDLIT: begin
          if (litleft_r != 7'd0) litleft_nxt = litleft_r - 7'd1;
          if (litleft_nxt == 7'd0) do_res = 1'b1;
        end
        PH_TERMLIT: begin
          if (litleft_r != 7'd0) litleft_nxt = litleft_r - 7'd1;
          if (litleft_nxt == 7'd0) do_term = 1'b1;
        end
        default: phase_nxt = PH_CONTROL;
      endcase

      if (sc_go) begin
        pcls_nxt = sc_cls;
        plen_nxt = sc_len;
        pdist_nxt = sc_dist;
        plits_nxt = sc_lits;
        litleft_nxt = sc_lits;
        if (sc_lits == 7'd0) begin
          do_res = 1'b1;
          r_cls = sc_cls;
          r_lits = sc_lits;
          r_len = sc_len;
          r_dist = sc_dist;
        end else begin
          phase_nxt = PH_CMDLIT;
        end
      end

      if (do_res) begin
        if ({15'd0, r_dist} > {1'b0, prod_r} + {26'd0, r_lits}) begin
          have_st = 1'b1;
          st = ST_DISTANCE;
          off = back_off(posn, {1'b0, r_lits});
        end else begin
          ev.do_cmd = 1'b1;
          ev.cls = r_cls;
          ev.lits = r_lits;
          ev.lit_bkt = lit_bucket(r_lits);
          ev.len = r_len;
          ev.len_bkt = len_bucket(r_len);
          ev.dist_bkt = dist_bucket(r_dist);
          ev.ovl = r_dist < {7'd0, r_len};
          prod_nxt = add_sat(add_sat(prod_r, {4'd0, r_lits}), r_len);
          phase_nxt = PH_CONTROL;
        end
      end

      if (do_term) begin
        ev.do_term = 1'b1;
        ev.lits = t_lits;
        ev.lit_bkt = lit_bucket(t_lits);
        prod_nxt = add_sat(prod_r, {4'd0, t_lits});
        have_st = 1'b1;
        if (prod_nxt != {8'd0, exp_r}) begin
          st = ST_MISMATCH;
          off = posn;
        end else begin
          st = ST_OK;
          off = 32'd0;
        end
      end

      if (!have_st && last_byte) begin
        have_st = 1'b1;
        unique case (phase_nxt)
          PH_HEADER: begin
            if (posn < 32'd5) begin
              st = ST_HEADER;
              off = posn;
            end else begin
              st = ST_SIZE;
              off = 32'd5;
            end
          end
          PH_SHORT1: begin st = ST_SHORT; off = posn; end
          PH_MED1: begin st = ST_MEDIUM; off = posn; end
          PH_MED2: begin st = ST_MEDIUM; off = back_off(posn, 8'd1); end
          PH_LONG1: begin st = ST_LONG; off = posn; end
          PH_LONG2: begin st = ST_LONG; off = back_off(posn, 8'd1); end
          PH_LONG3: begin st = ST_LONG; off = back_off(posn, 8'd2); end
          PH_CMDLIT: begin
            st = ST_CMDLIT;
            off = back_off(posn, {1'b0, plits_nxt - litleft_nxt});
          end
          PH_TERMLIT: begin
            st = ST_TERMLIT;
            off = back_off(posn, {1'b0, {5'd0, cb0_nxt[1:0]} - litleft_nxt});
          end
          default: begin st = ST_NOCTRL; off = posn; end
        endcase
      end

      if (have_st) begin
        ev.do_run = 1'b1;
        ev.status = st;
        ev.offset = off;
        ev.produced = prod_nxt;
        if (last_byte) ev.do_clear = 1'b1;
        else absorb_nxt = 1'b1;
      end
    end

    if (ev.do_clear) begin
      phase_nxt = PH_HEADER;
      pos_nxt = '0;
      lhf_nxt = 1'b0;
      exp_nxt = '0;
      prod_nxt = '0;
      litleft_nxt = '0;
      plits_nxt = '0;
      plen_nxt = '0;
      pdist_nxt = '0;
      pcls_nxt = '0;
      absorb_nxt = 1'b0;
    end

    ev_valid = ev.do_cmd | ev.do_term | ev.do_run | ev.do_clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r <= '0;
      lhf_r <= 1'b0;
      exp_r <= '0;
      prod_r <= '0;
      litleft_r <= '0;
      plits_r <= '0;
      plen_r <= '0;
      pdist_r <= '0;
      pcls_r <= '0;
      absorb_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      lhf_r <= lhf_nxt;
      exp_r <= exp_nxt;
      prod_r <= prod_nxt;
      litleft_r <= litleft_nxt;
      plits_r <= plits_nxt;
      plen_r <= plen_nxt;
      pdist_r <= pdist_nxt;
      pcls_r <= pcls_nxt;
      absorb_r <= absorb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cb0_r <= cb0_nxt;
      cb1_r <= cb1_nxt;
      cb2_r <= cb2_nxt;
    end
  end

endmodule

@@ rtl/core/rsp_evq.sv @@
// short event queue between parser and counter bank
module rsp_evq
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rsp_event_t push_ev,
  input  logic       pop,
  output logic       empty,
  output logic       full,
  output rsp_event_t head_ev
);

  localparam int PW = $clog2(EVQ_DEPTH);

  rsp_event_t       mem [EVQ_DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r;

  assign empty = (count_r == '0);
  assign full = (count_r == (PW+1)'(EVQ_DEPTH));
  assign head_ev = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10: count_r <= count_r + 1'b1;
        2'b01: count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/rsp_back.sv @@
// back end: statistics counter bank and result run sequencer
module rsp_back
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  rsp_event_t  q_ev,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_counter_index,
  output logic [31:0] out_counter_value,
  output logic [3:0]  out_status,
  output logic [31:0] out_fault_pos,
  output logic [31:0] out_produced_size,
  output logic        out_run_last
);

  logic [COUNTER_BITS-1:0] cnt_r [NUM_CNT];
  logic [COUNTER_BITS-1:0] inc [NUM_CNT];
  logic                    run_r;
  logic                    clr_pend_r;
  logic [4:0]              idx_r;
  logic [3:0]              st_r;
  logic [31:0]             off_r, prod_r;
  logic                    run_end;
  logic [63:0]             wide;

  assign q_pop = !q_empty && !run_r;
  assign run_end = run_r && out_pop && (idx_r == IDX_LAST);

  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      inc[i] = '0;
      if (q_ev.do_cmd) begin
        if (5'(i) == IDX_CMD) inc[i] = COUNTER_BITS'(1);
        if (5'(i) == IDX_CLASS + {3'd0, q_ev.cls}) inc[i] = COUNTER_BITS'(1);
        if (q_ev.len != 11'd0) begin
          if (5'(i) == IDX_MATCHB) inc[i] = COUNTER_BITS'(q_ev.len);
          if (5'(i) == IDX_OVLB && q_ev.ovl) inc[i] = COUNTER_BITS'(q_ev.len);
          if (5'(i) == IDX_LENBKT + {2'd0, q_ev.len_bkt}) inc[i] = COUNTER_BITS'(1);
          if (5'(i) == IDX_DISTBKT + {1'd0, q_ev.dist_bkt}) inc[i] = COUNTER_BITS'(1);
        end
      end
      if (q_ev.do_cmd || q_ev.do_term) begin
        if (5'(i) == IDX_LITB) inc[i] = COUNTER_BITS'(q_ev.lits);
        if (5'(i) == IDX_LITBKT + {2'd0, q_ev.lit_bkt}) inc[i] = COUNTER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CNT; i++) cnt_r[i] <= '0;
    end else if (run_end && clr_pend_r) begin
      for (int i = 0; i < NUM_CNT; i++) cnt_r[i] <= '0;
    end else if (q_pop) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (q_ev.do_clear && !q_ev.do_run) cnt_r[i] <= '0;
        else if (inc[i] > ~cnt_r[i]) cnt_r[i] <= '1;
        else cnt_r[i] <= cnt_r[i] + inc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      clr_pend_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop && q_ev.do_run) begin
      run_r <= 1'b1;
      clr_pend_r <= q_ev.do_clear;
      idx_r <= '0;
    end else if (run_r && out_pop) begin
      idx_r <= idx_r + 5'd1;
      if (idx_r == IDX_LAST) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_ev.do_run) begin
      st_r <= q_ev.status;
      off_r <= q_ev.offset;
      prod_r <= q_ev.produced;
    end
  end

  assign wide = 64'(cnt_r[idx_r]);
  assign out_empty = !run_r;
  assign out_counter_index = idx_r;
  assign out_counter_value = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  assign out_status = st_r;
  assign out_fault_pos = off_r;
  assign out_produced_size = prod_r;
  assign out_run_last = (idx_r == IDX_LAST);

endmodule

@@ rtl/core/refpack_stream_profiler.sv @@
// top level of the compressed stream profiler
// Usage:
//   Input queue: drive in_stream_byte and in_last_byte with push; a byte is
//   taken at a clock edge with push high and full low. One byte per cycle is
//   sustained while the parser's event queue has room.
//   Result queue: while out_empty is low the oldest result is on the out_
//   ports; pop high takes it. A report is a run of 32 results, counter
//   index 0 to 31, with out_run_last high on the final one.
//   Run start: a run begins when the event of the byte that ends the stream or
//   hits an error is popped from the queue, once earlier events have drained.
//   Throughput: one byte per cycle; the counter bank applies one event per
//   cycle and holds the queue while a run is shown, so input
//   stalls only behind a report.
//   A stalled receiver holds the current result; the four-entry event
//   queue then fills and full rises.
//   Reset (rst_n low, synchronous) clears parser state, queue and all
//   counters; the byte marked last clears parser state and counters for the next stream.
`include "refpack_stream_profiler_macros.svh"
module refpack_stream_profiler
  import rsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_counter_index,
  output logic [31:0] out_counter_value,
  output logic [3:0]  out_status,
  output logic [31:0] out_fault_pos,
  output logic [31:0] out_produced_size,
  output logic        out_run_last
);

  logic       acc;
  logic       ev_valid;
  rsp_event_t ev;
  logic       q_empty, q_full, q_pop;
  rsp_event_t q_ev;

  assign acc = in_push && !q_full;
  assign in_full = q_full;

  rsp_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .stream_byte(in_stream_byte), .last_byte(in_last_byte),
    .ev_valid(ev_valid), .ev(ev)
  );

  rsp_evq u_evq (
    .clk(clk), .rst_n(rst_n),
    .push(acc && ev_valid), .push_ev(ev),
    .pop(q_pop), .empty(q_empty), .full(q_full), .head_ev(q_ev)
  );

  rsp_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_ev(q_ev), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_counter_index(out_counter_index), .out_counter_value(out_counter_value),
    .out_status(out_status), .out_fault_pos(out_fault_pos),
    .out_produced_size(out_produced_size), .out_run_last(out_run_last)
  );

  `RSP_ASSERT(a_run_continues, out_pop && !out_empty && !out_run_last |=> !out_empty, "run broke off early")
  `RSP_ASSERT(a_index_steps, out_pop && !out_empty && !out_run_last |=> out_counter_index == $past(out_counter_index) + 5'd1, "counter index skipped")
  `RSP_ASSERT(a_ok_no_offset, !out_empty && out_status == ST_OK |-> out_fault_pos == 32'd0, "ok status with offset")
  `RSP_ASSERT(a_no_pop_in_run, !out_empty |-> !q_pop, "event consumed during run")

endmodule
